@@ rtl/u8n1_pkg.sv @@
// Shared types and constants for the tick-driven 8N1 UART transceiver.
`default_nettype none

package u8n1_pkg;

  // Default build values.
  localparam int DATA_BITS_DEF   = 8;
  localparam int PERIOD_BITS_DEF = 16;

  // Fixed field and bus widths.
  localparam int BYTE_W      = 8;
  localparam int CFG_W       = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // Bit period after reset.
  localparam logic [CFG_W-1:0] BIT_PERIOD_RST = 16'd104;

  // Per-tick transmitter result.
  typedef struct packed {
    logic level;
    logic accepted;
    logic busy;
  } tx_res_t;

  // Per-tick receiver result.
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } rx_res_t;

endpackage : u8n1_pkg

`default_nettype wire

@@ rtl/u8n1_tx.sv @@
// Transmit frame sequencer: start bit, data bits LSB first, stop bit.
`default_nettype none

module u8n1_tx #(
  parameter int DATA_BITS   = 8,
  parameter int PERIOD_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic [PERIOD_BITS-1:0]     period,
  input  wire logic                       req,
  input  wire logic [u8n1_pkg::BYTE_W-1:0] req_byte,
  output u8n1_pkg::tx_res_t               res
);
  import u8n1_pkg::*;

  localparam int PH_W = $clog2(DATA_BITS + 3);
  localparam logic [PH_W-1:0] PH_IDLE       = PH_W'(0);
  localparam logic [PH_W-1:0] PH_START      = PH_W'(1);
  localparam logic [PH_W-1:0] PH_FIRST_DATA = PH_W'(2);
  localparam logic [PH_W-1:0] PH_LAST_DATA  = PH_W'(DATA_BITS + 1);
  localparam logic [PH_W-1:0] PH_STOP       = PH_W'(DATA_BITS + 2);

  logic [PH_W-1:0]        phase_r, phase_nxt, cur_phase;
  logic [PERIOD_BITS-1:0] timer_r, timer_nxt, cur_timer;
  logic [BYTE_W-1:0]      shift_r, shift_nxt, cur_shift;
  logic [PERIOD_BITS:0]   timer_inc;
  logic [PH_W-1:0]        bit_idx;

  // Next-state and line level for this tick.
  always_comb begin
    cur_phase    = phase_r;
    cur_timer    = timer_r;
    cur_shift    = shift_r;
    res.level    = 1'b1;
    res.accepted = 1'b0;
    res.busy     = 1'b0;
    bit_idx      = cur_phase - PH_FIRST_DATA;
    timer_inc    = '0;
    phase_nxt    = phase_r;
    timer_nxt    = timer_r;

    // A request is taken only when idle; the start bit goes out at once.
    if (phase_r == PH_IDLE && req) begin
      cur_phase    = PH_START;
      cur_timer    = '0;
      cur_shift    = req_byte;
      res.accepted = 1'b1;
    end
    bit_idx = cur_phase - PH_FIRST_DATA;

    if (cur_phase != PH_IDLE) begin
      res.busy = 1'b1;
      if (cur_phase == PH_START) begin
        res.level = 1'b0;
      end else if (cur_phase <= PH_LAST_DATA) begin
        // Bits beyond the byte are sent as zero on wide frames.
        res.level = (32'(bit_idx) < 32'd8) ? cur_shift[bit_idx[2:0]] : 1'b0;
      end
      timer_inc = {1'b0, cur_timer} + (PERIOD_BITS+1)'(1);
      if (timer_inc >= {1'b0, period}) begin
        timer_nxt = '0;
        phase_nxt = (cur_phase == PH_STOP) ? PH_IDLE : cur_phase + PH_W'(1);
      end else begin
        timer_nxt = timer_inc[PERIOD_BITS-1:0];
        phase_nxt = cur_phase;
      end
    end
    shift_nxt = cur_shift;
  end

  // State registers advance once per processed tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      timer_r <= '0;
      shift_r <= '0;
    end else if (en) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      shift_r <= shift_nxt;
    end
  end

endmodule : u8n1_tx

`default_nettype wire

@@ rtl/u8n1_rx.sv @@
// Receive sampler: start detect, mid-bit sampling, delayed byte delivery.
`default_nettype none

module u8n1_rx #(
  parameter int DATA_BITS   = 8,
  parameter int PERIOD_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic [PERIOD_BITS-1:0] period,
  input  wire logic                   rx_level,
  output u8n1_pkg::rx_res_t           res
);
  import u8n1_pkg::*;

  localparam int PH_W = $clog2(DATA_BITS + 3);
  localparam int RT_W = PERIOD_BITS + 1;
  localparam logic [PH_W-1:0] PH_IDLE      = PH_W'(0);
  localparam logic [PH_W-1:0] PH_FIRST     = PH_W'(1);
  localparam logic [PH_W-1:0] PH_LAST_DATA = PH_W'(DATA_BITS);

  logic [PH_W-1:0]   phase_r, phase_nxt;
  logic [RT_W-1:0]   timer_r, timer_nxt, timer_dec;
  logic [BYTE_W-1:0] shift_r, shift_nxt;
  logic [RT_W-1:0]   reload_long;
  logic [PH_W-1:0]   bit_idx;

  // One and a half periods, used for the first sample and for delivery.
  assign reload_long = RT_W'(period) + RT_W'(period >> 1);
  assign bit_idx     = phase_r - PH_FIRST;
  assign timer_dec   = (timer_r != '0) ? timer_r - RT_W'(1) : timer_r;

  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    shift_nxt = shift_r;
    res.valid = 1'b0;
    res.data  = '0;

    if (phase_r == PH_IDLE) begin
      // A low line while idle starts a frame.
      if (!rx_level) begin
        phase_nxt = PH_FIRST;
        shift_nxt = '0;
        timer_nxt = reload_long;
      end
    end else begin
      timer_nxt = timer_dec;
      if (timer_dec == '0) begin
        if (phase_r <= PH_LAST_DATA) begin
          // Sample one data bit; bits beyond the byte are dropped.
          if (rx_level && 32'(bit_idx) < 32'd8) begin
            shift_nxt[bit_idx[2:0]] = 1'b1;
          end
          phase_nxt = phase_r + PH_W'(1);
          timer_nxt = (phase_r < PH_LAST_DATA) ? RT_W'(period) : reload_long;
        end else begin
          res.valid = 1'b1;
          res.data  = shift_r;
          phase_nxt = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      timer_r <= '0;
      shift_r <= '0;
    end else if (en) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      shift_r <= shift_nxt;
    end
  end

endmodule : u8n1_rx

`default_nettype wire

@@ rtl/uart_8n1_transceiver_top.sv @@
// A result reaches out_tdata via the input register and then the output register.
// One tick per cycle unless out_tready stalls; the input register feeds the transmit
// and receive next-state logic, which loads the output register in one pass.
// The output register lets a new request enter while a result waits to be taken.
// Reset (rst_n low, synchronous) idles both directions and sets bit_period to 104.
`default_nettype none

module uart_8n1_transceiver_top #(
  parameter int DATA_BITS   = u8n1_pkg::DATA_BITS_DEF,
  parameter int PERIOD_BITS = u8n1_pkg::PERIOD_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Configuration: bit_period.
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [u8n1_pkg::CFG_W-1:0]       cfg_data,
  // Tick requests.
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  // [0] rx_level, [1] send_request, [9:2] send_byte, [15:10] zero
  input  wire logic [u8n1_pkg::IN_TDATA_W-1:0]  in_tdata,
  // Tick results.
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  // [0] tx_level, [1] send_accepted, [2] tx_busy, [3] rx_valid,
  // [11:4] rx_data, [12] line_busy, [15:13] zero
  output      logic [u8n1_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import u8n1_pkg::*;

  logic                   s1_valid_r;
  logic                   s1_rx_level_r;
  logic                   s1_req_r;
  logic [BYTE_W-1:0]      s1_byte_r;
  logic [CFG_W-1:0]       bit_period_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   advance;
  logic [31:0]            period_wide;
  logic [PERIOD_BITS-1:0] period_raw, period;
  tx_res_t                tx_res;
  rx_res_t                rx_res;

  assign cfg_ready  = 1'b1;
  assign advance    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Only the low PERIOD_BITS bits count; a zero period acts as one.
  assign period_wide = {16'b0, bit_period_r};
  assign period_raw  = period_wide[PERIOD_BITS-1:0];
  assign period      = (period_raw == '0) ? PERIOD_BITS'(1) : period_raw;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= BIT_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      bit_period_r <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_rx_level_r <= in_tdata[0];
      s1_req_r      <= in_tdata[1];
      s1_byte_r     <= in_tdata[9:2];
    end
  end

  u8n1_tx #(
    .DATA_BITS  (DATA_BITS),
    .PERIOD_BITS(PERIOD_BITS)
  ) u_tx (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (advance),
    .period  (period),
    .req     (s1_req_r),
    .req_byte(s1_byte_r),
    .res     (tx_res)
  );

  u8n1_rx #(
    .DATA_BITS  (DATA_BITS),
    .PERIOD_BITS(PERIOD_BITS)
  ) u_rx (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (advance),
    .period  (period),
    .rx_level(s1_rx_level_r),
    .res     (rx_res)
  );

  // Pack the result fields, highest field first.
  assign out_data_nxt = {3'b000, ~s1_rx_level_r, rx_res.data, rx_res.valid,
                         tx_res.busy, tx_res.accepted, tx_res.level};

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule : uart_8n1_transceiver_top

`default_nettype wire
